// ===== hw/rtl/vigenere_27_symbol_cipher_top_assert.svh =====
// Assertion macros for the 27-symbol Vigenere cipher RTL.
// Used by files that check their own logic; needs signals clk and rst in scope.
`ifndef VIGENERE_27_SYMBOL_CIPHER_TOP_ASSERT_SVH
`define VIGENERE_27_SYMBOL_CIPHER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Check that cond holds at every clock edge out of reset.
`define VIG27_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Check that cons holds in the cycle after ante.
`define VIG27_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VIG27_ASSERT(name, cond, msg)
`define VIG27_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/vig27_pkg.sv =====
// Shared types, constants and symbol helpers for the 27-symbol Vigenere cipher.
// No dependencies.
package vig27_pkg;

  localparam int KEY_DEPTH = 512;
  localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int ALPHA_LEN = 27;

  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_Z = 8'h7A;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_CIPHER = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_DIRECTION  = 1'b0,
    REG_KEY_LENGTH = 1'b1
  } reg_idx_t;

  // Character held between the key read and the shift.
  typedef struct packed {
    logic       is_alpha;
    logic [4:0] sym;
    logic [7:0] upper;
  } char_info_t;

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CHR_LOWER_A && b <= CHR_LOWER_Z) r = b - 8'd32;
    return r;
  endfunction

  function automatic char_info_t classify(input logic [7:0] b);
    char_info_t ci;
    ci.upper    = to_upper(b);
    ci.is_alpha = 1'b0;
    ci.sym      = 5'd0;
    if (ci.upper == CHR_SPACE) begin
      ci.is_alpha = 1'b1;
    end else if (ci.upper >= CHR_UPPER_A && ci.upper <= CHR_UPPER_Z) begin
      ci.is_alpha = 1'b1;
      ci.sym      = 5'(ci.upper - CHR_UPPER_A + 8'd1);
    end
    return ci;
  endfunction

  function automatic logic [7:0] byte_of(input logic [4:0] sym);
    logic [7:0] r;
    r = (sym == 5'd0) ? CHR_SPACE : (CHR_UPPER_A + {3'd0, sym} - 8'd1);
    return r;
  endfunction

endpackage

// ===== hw/rtl/vig27_key_ram.sv =====
// Key store: single-port-write, single-read synchronous RAM with a registered read.
// Depends on vig27_pkg.
module vig27_key_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [vig27_pkg::KEY_AW-1:0] waddr,
  input  logic [4:0]                  wdata,
  input  logic                        re,
  input  logic [vig27_pkg::KEY_AW-1:0] raddr,
  output logic [4:0]                  rdata
);

  logic [4:0] mem [vig27_pkg::KEY_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/vig27_shift.sv =====
// Modulo-27 shift of one symbol by a key entry, and mapping back to a byte.
// Depends on vig27_pkg.
module vig27_shift (
  input  vig27_pkg::char_info_t info,
  input  logic [4:0]            key,
  input  logic                  direction,
  output logic [7:0]            char_out
);

  logic [4:0] shift;
  logic [5:0] sum;
  logic [5:0] sum_red;

  always_comb begin
    // stored shifts above 26 wrap once
    shift = (key >= 5'(vig27_pkg::ALPHA_LEN)) ? key - 5'(vig27_pkg::ALPHA_LEN) : key;
    if (direction)
      sum = {1'b0, info.sym} + 6'(vig27_pkg::ALPHA_LEN) - {1'b0, shift};
    else
      sum = {1'b0, info.sym} + {1'b0, shift};
    sum_red = (sum >= 6'(vig27_pkg::ALPHA_LEN)) ? sum - 6'(vig27_pkg::ALPHA_LEN) : sum;
    char_out = info.is_alpha ? vig27_pkg::byte_of(sum_red[4:0]) : info.upper;
  end

endmodule

// ===== hw/rtl/vigenere_27_symbol_cipher_top.sv =====
// Top level of the streaming 27-symbol Vigenere cipher.
// Depends on vig27_pkg, vig27_key_ram, vig27_shift and the assertion macro header.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per handshake: a load
//   item (command 0) writes key_shift into key store slot key_slot; a cipher
//   item (command 1) uppercases char_in and, for space or A..Z, shifts it by
//   the key entry under the key pointer modulo 27 (add when direction is 0,
//   subtract when 1). Other bytes leave uppercased but otherwise unchanged.
//   message_start on a cipher item restarts the key pointer at 0.
//   Output channel (out_valid/out_ready) returns one char_out per cipher item,
//   in order; load items produce nothing.
//   Path: a cipher item is registered in the read stage (key store read and
//   classified character), then shifted into the output register.
//   Throughput: one item per cycle while the output is not stalled, set by
//   the key store read port and the pointer increment that carries item to item.
//   Stall: when out_ready is low with a result waiting, one more cipher item
//   can sit in the read stage; after that in_ready drops until the output drains.
//   Reset (rst, synchronous): clears the pipeline, the key pointer, direction=0
//   and key_length=1. The key store is not cleared; load entries before use.
//   Config (cfg_we/cfg_index/cfg_data): user writes only while idle; not enforced.
`include "vigenere_27_symbol_cipher_top_assert.svh"

module vigenere_27_symbol_cipher_top (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [9:0] cfg_data,
  // input item
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [8:0] key_slot,
  input  logic [4:0] key_shift,
  input  logic [7:0] char_in,
  input  logic       message_start,
  // result item
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] char_out
);

  localparam int AW = vig27_pkg::KEY_AW;

  // configuration registers
  logic       direction;
  logic [9:0] key_length;

  // key pointer
  logic [AW-1:0] key_ptr;
  logic [AW-1:0] key_ptr_next;
  logic [AW-1:0] ptr_eff;
  logic [AW:0]   ptr_inc;

  // read stage
  logic                  s1_valid;
  vig27_pkg::char_info_t s1_info;
  logic [4:0]            key_rdata;

  logic       in_acc;
  logic       is_cipher;
  logic       is_load;
  logic       advance;
  logic [7:0] shifted;
  logic       slot_ok;

  assign is_cipher = (vig27_pkg::cmd_t'(command) == vig27_pkg::CMD_CIPHER);
  assign is_load   = (vig27_pkg::cmd_t'(command) == vig27_pkg::CMD_LOAD);

  // output register free this cycle
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance || !s1_valid;
  assign in_acc   = in_valid && in_ready;

  // drop loads aimed beyond the store
  assign slot_ok = (32'(key_slot) < 32'(vig27_pkg::KEY_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= 1'b0;
      key_length <= 10'd1;
    end else if (cfg_we) begin
      case (vig27_pkg::reg_idx_t'(cfg_index))
        vig27_pkg::REG_DIRECTION:  direction  <= cfg_data[0];
        vig27_pkg::REG_KEY_LENGTH: key_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pointer: restart on message_start, wrap at key_length or store depth.
  always_comb begin
    ptr_eff = message_start ? '0 : key_ptr;
    ptr_inc = {1'b0, ptr_eff} + (AW+1)'(1);
    if (32'(ptr_inc) >= 32'(key_length) || 32'(ptr_inc) >= 32'(vig27_pkg::KEY_DEPTH))
      key_ptr_next = '0;
    else
      key_ptr_next = ptr_inc[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) key_ptr <= '0;
    else if (in_acc && is_cipher) key_ptr <= key_ptr_next;
  end

  // Loads write at their accept edge; a cipher item accepted later reads the
  // new value, and only one item is accepted per edge, so no bypass is needed.
  vig27_key_ram u_key_ram (
    .clk   (clk),
    .we    (in_acc && is_load && slot_ok),
    .waddr (AW'(key_slot)),
    .wdata (key_shift),
    .re    (in_acc && is_cipher),
    .raddr (ptr_eff),
    .rdata (key_rdata)
  );

  // Read stage: hold the classified character next to the key read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_acc && is_cipher;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_cipher) s1_info <= vig27_pkg::classify(char_in);
  end

  vig27_shift u_shift (
    .info      (s1_info),
    .key       (key_rdata),
    .direction (direction),
    .char_out  (shifted)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) char_out <= shifted;
  end

  `VIG27_ASSERT(a_ready_only_when_full, in_ready || s1_valid, "in_ready low with empty read stage")
  `VIG27_ASSERT_NEXT(a_load_keeps_ptr, in_acc && is_load, key_ptr == $past(key_ptr), "load item moved the key pointer")
  `VIG27_ASSERT_NEXT(a_cipher_fills_s1, in_acc && is_cipher, s1_valid, "accepted cipher item lost before read stage")
  `VIG27_ASSERT_NEXT(a_s1_to_out, s1_valid && advance, out_valid, "read stage result not moved to output")

endmodule
